@@ src/u8d_pkg.sv @@
// Shared types, constants and lookup functions for the UTF-8 stream decoder.
package u8d_pkg;

   // Default width of the internal code point counter
   localparam int COUNT_WIDTH_DEFAULT = 32;
   // Depth of the queue between the classifier and the decoder core
   localparam int MID_DEPTH = 2;
   // Depth of the result queue
   localparam int OUT_DEPTH = 2;

   localparam int CHAR_COUNT_WIDTH = 32;
   localparam int CODE_POINT_WIDTH = 21;

   // DFA state codes
   localparam logic [3:0] ST_ACCEPT = 4'd0;
   localparam logic [3:0] ST_REJECT = 4'd1;
   localparam logic [3:0] ST_LAST   = 4'd8;

   // Status codes reported per beat
   localparam logic [1:0] STATUS_ACCEPT  = 2'd0;
   localparam logic [1:0] STATUS_PENDING = 2'd1;
   localparam logic [1:0] STATUS_REJECT  = 2'd2;

   // Byte classes
   localparam logic [3:0] CLS_ASCII    = 4'd0;
   localparam logic [3:0] CLS_CONT_LO  = 4'd1;
   localparam logic [3:0] CLS_LEAD2    = 4'd2;
   localparam logic [3:0] CLS_LEAD3    = 4'd3;
   localparam logic [3:0] CLS_LEAD_ED  = 4'd4;
   localparam logic [3:0] CLS_LEAD_F4  = 4'd5;
   localparam logic [3:0] CLS_LEAD4    = 4'd6;
   localparam logic [3:0] CLS_CONT_HI  = 4'd7;
   localparam logic [3:0] CLS_INVALID  = 4'd8;
   localparam logic [3:0] CLS_CONT_MID = 4'd9;
   localparam logic [3:0] CLS_LEAD_E0  = 4'd10;
   localparam logic [3:0] CLS_LEAD_F0  = 4'd11;

   // Transition table indexed by state, then byte class
   localparam logic [3:0] NEXT_STATE_TABLE [0:8][0:11] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
   };

   // Input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [CODE_POINT_WIDTH-1:0] code_point;
      logic                        code_done;
      logic [1:0]                  status;
      logic                        string_valid;
      logic [CHAR_COUNT_WIDTH-1:0] char_count;
   } rsp_type;

   // Classified beat passed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [3:0] char_class;
   } cls_item_type;

   // Map a raw byte to its character class
   function automatic logic [3:0] byte_class(input logic [7:0] b);
      logic [3:0] cls;
      if (b < 8'h80)       cls = CLS_ASCII;
      else if (b < 8'h90)  cls = CLS_CONT_LO;
      else if (b < 8'hA0)  cls = CLS_CONT_MID;
      else if (b < 8'hC0)  cls = CLS_CONT_HI;
      else if (b < 8'hC2)  cls = CLS_INVALID;
      else if (b < 8'hE0)  cls = CLS_LEAD2;
      else if (b == 8'hE0) cls = CLS_LEAD_E0;
      else if (b == 8'hED) cls = CLS_LEAD_ED;
      else if (b < 8'hF0)  cls = CLS_LEAD3;
      else if (b == 8'hF0) cls = CLS_LEAD_F0;
      else if (b < 8'hF4)  cls = CLS_LEAD4;
      else if (b == 8'hF4) cls = CLS_LEAD_F4;
      else                 cls = CLS_INVALID;
      return cls;
   endfunction

   // DFA transition; out-of-range states behave as reject
   function automatic logic [3:0] next_state(input logic [3:0] st, input logic [3:0] cls);
      logic [3:0] nst;
      if (st > ST_LAST || cls > CLS_LEAD_F0) nst = ST_REJECT;
      else                                   nst = NEXT_STATE_TABLE[st][cls];
      return nst;
   endfunction

endpackage

@@ src/u8d_fifo.sv @@
// Small synchronous FIFO used between the decoder stages and on the result side.
module u8d_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/u8d_front.sv @@
// Front stage: accepts input beats and registers each byte with its class.
module u8d_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  u8d_pkg::req_type      req_item,
   output logic                  req_full,
   output logic                  mid_push,
   output u8d_pkg::cls_item_type mid_item,
   input  logic                  mid_full
);

   logic                  stage_valid_ff, stage_valid_in;
   u8d_pkg::cls_item_type stage_item_ff;
   logic                  accept;
   logic                  drain;

   assign req_full = stage_valid_ff && mid_full;
   assign accept   = req_push && !req_full;
   assign drain    = stage_valid_ff && !mid_full;
   assign mid_push = drain;
   assign mid_item = stage_item_ff;

   // stage occupancy
   assign stage_valid_in = accept || (stage_valid_ff && !drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // classify on capture
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff.data_byte  <= req_item.data_byte;
         stage_item_ff.last_byte  <= req_item.last_byte;
         stage_item_ff.char_class <= u8d_pkg::byte_class(req_item.data_byte);
      end
   end

endmodule

@@ src/u8d_back.sv @@
// Back stage: DFA step, code point assembly and per-string counting.
module u8d_back #(
   parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mid_empty,
   input  u8d_pkg::cls_item_type mid_item,
   output logic                  mid_pop,
   input  logic                  out_full,
   output logic                  out_push,
   output u8d_pkg::rsp_type      out_item
);

   logic [3:0]                           state_ff, state_in;
   logic [u8d_pkg::CODE_POINT_WIDTH-1:0] acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0]               cnt_ff, cnt_in;
   logic [3:0]                           nst;
   logic                                 done;
   logic [COUNT_WIDTH-1:0]               cnt_next;
   logic [u8d_pkg::CODE_POINT_WIDTH-1:0] acc_next;
   logic [7:0]                           lead_bits;
   logic [u8d_pkg::CHAR_COUNT_WIDTH-1:0] count_report;
   logic                                 proc;

   // one beat per cycle when there is input and room for the result
   assign proc     = !mid_empty && !out_full;
   assign mid_pop  = proc;
   assign out_push = proc;

   // accumulator and transition
   always_comb begin
      lead_bits = (8'hFF >> mid_item.char_class) & mid_item.data_byte;
      if (state_ff != u8d_pkg::ST_ACCEPT) begin
         acc_next = {acc_ff[u8d_pkg::CODE_POINT_WIDTH-7:0], mid_item.data_byte[5:0]};
      end else begin
         acc_next = {{(u8d_pkg::CODE_POINT_WIDTH - 8){1'b0}}, lead_bits};
      end
      nst      = u8d_pkg::next_state(state_ff, mid_item.char_class);
      done     = (nst == u8d_pkg::ST_ACCEPT);
      cnt_next = (done && cnt_ff != '1) ? cnt_ff + 1'b1 : cnt_ff;
   end

   // clamp the counter to the 32-bit report field
   generate
      if (COUNT_WIDTH > u8d_pkg::CHAR_COUNT_WIDTH) begin : g_wide_cnt
         assign count_report = (|cnt_next[COUNT_WIDTH-1:u8d_pkg::CHAR_COUNT_WIDTH])
                               ? '1 : cnt_next[u8d_pkg::CHAR_COUNT_WIDTH-1:0];
      end else begin : g_narrow_cnt
         assign count_report = u8d_pkg::CHAR_COUNT_WIDTH'(cnt_next);
      end
   endgenerate

   // result beat
   always_comb begin
      out_item.code_point   = done ? acc_next : '0;
      out_item.code_done    = done;
      if (nst == u8d_pkg::ST_ACCEPT) begin
         out_item.status = u8d_pkg::STATUS_ACCEPT;
      end else if (nst == u8d_pkg::ST_REJECT) begin
         out_item.status = u8d_pkg::STATUS_REJECT;
      end else begin
         out_item.status = u8d_pkg::STATUS_PENDING;
      end
      out_item.string_valid = mid_item.last_byte && done;
      out_item.char_count   = (mid_item.last_byte && done) ? count_report : '0;
   end

   // state update; end of string returns to reset values
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      if (proc) begin
         if (mid_item.last_byte) begin
            state_in = u8d_pkg::ST_ACCEPT;
            acc_in   = '0;
            cnt_in   = '0;
         end else begin
            state_in = nst;
            acc_in   = acc_next;
            cnt_in   = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u8d_pkg::ST_ACCEPT;
         acc_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
      end
   end

   // checks
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      state_ff <= u8d_pkg::ST_LAST)
      else $error("DFA state out of range");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      proc && mid_item.last_byte |=> state_ff == u8d_pkg::ST_ACCEPT && cnt_ff == '0)
      else $error("state not cleared after end of string");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      proc && out_item.code_done |-> out_item.status == u8d_pkg::STATUS_ACCEPT)
      else $error("completed code point without accept status");

   a_valid_last: assert property (@(posedge clock) disable iff (reset)
      proc && out_item.string_valid |-> mid_item.last_byte)
      else $error("string_valid outside last byte");

endmodule

@@ src/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder: front classifier, queue, DFA core, result queue.
//
// Usage:
//   Input channel: drive req_item (data_byte, last_byte) and raise req_push;
//   a beat is taken at a rising edge with req_push high and req_full low.
//   last_byte marks the final byte of a string; a zero byte is ordinary data.
//   Result channel: while rsp_empty is low, rsp_item holds the oldest result;
//   raising rsp_pop takes it at the next rising edge. One result per byte.
//   Each result gives the completed code point (with code_done), the DFA
//   status, and on the last byte string_valid and char_count.
// Timing:
//   One byte per cycle sustained while the receiver keeps popping. A result
//   reaches rsp_item through the front register, the inner queue, and the
//   result queue written by the DFA core. The DFA core's state update
//   sets the rate.
// Reset and stall:
//   reset (synchronous, active high) empties both queues and returns the DFA
//   to the accept state with zero count. When the receiver stops popping,
//   the result queue fills, the core stops, the inner queue fills, and
//   req_full rises; no beat is lost or repeated.
module utf8_stream_decoder #(
   parameter int COUNT_WIDTH = u8d_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  u8d_pkg::req_type req_item,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output u8d_pkg::rsp_type rsp_item
);

   localparam int CLS_W = $bits(u8d_pkg::cls_item_type);
   localparam int RSP_W = $bits(u8d_pkg::rsp_type);

   logic                  mid_push;
   logic                  mid_full;
   logic                  mid_pop;
   logic                  mid_empty;
   u8d_pkg::cls_item_type mid_wr_item;
   u8d_pkg::cls_item_type mid_rd_item;
   logic                  out_push;
   logic                  out_full;
   u8d_pkg::rsp_type      out_wr_item;

   // byte capture and classification
   u8d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .mid_push (mid_push),
      .mid_item (mid_wr_item),
      .mid_full (mid_full)
   );

   // queue between front and back
   u8d_fifo #(
      .WIDTH (CLS_W),
      .DEPTH (u8d_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wr_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rd_item),
      .empty     (mid_empty)
   );

   // DFA core
   u8d_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_item  (mid_rd_item),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_wr_item)
   );

   // result queue
   u8d_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (u8d_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wr_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

endmodule

@@ test/utf8_stream_decoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-8 stream decoder: directed byte table, then random strings.
module utf8_stream_decoder_tb;

   // Run control
   localparam int RANDOM_BYTES = 850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 100;

   // Intermediate DFA states: continuation bytes still owed
   localparam logic [3:0] S_NEED1    = 4'd2;
   localparam logic [3:0] S_NEED2    = 4'd3;
   localparam logic [3:0] S_AFTER_E0 = 4'd4;
   localparam logic [3:0] S_AFTER_ED = 4'd5;
   localparam logic [3:0] S_AFTER_F0 = 4'd6;
   localparam logic [3:0] S_NEED3    = 4'd7;
   localparam logic [3:0] S_AFTER_F4 = 4'd8;

   // Ways a generated character gets damaged
   localparam int BREAK_NONE    = 0;
   localparam int BREAK_TRUNC   = 1;
   localparam int BREAK_CORRUPT = 2;

   // Directed rows: typed rows carry their own expected result
   localparam logic TYPED = 1'b1;
   localparam logic PRED  = 1'b0;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [20:0] cp;
      logic        done;
      logic [1:0]  status;
      logic        valid;
      logic [31:0] count;
   } dir_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam dir_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // one-byte strings: NUL, top ASCII, invalid bytes, stray continuation
      '{8'h00, 1'b1, TYPED, 21'h00, 1'b1, u8d_pkg::STATUS_ACCEPT, 1'b1, 32'd1},
      '{8'h7F, 1'b1, TYPED, 21'h7F, 1'b1, u8d_pkg::STATUS_ACCEPT, 1'b1, 32'd1},
      '{8'hFF, 1'b1, TYPED, 21'h00, 1'b0, u8d_pkg::STATUS_REJECT, 1'b0, 32'd0},
      '{8'hC0, 1'b1, TYPED, 21'h00, 1'b0, u8d_pkg::STATUS_REJECT, 1'b0, 32'd0},
      '{8'h80, 1'b1, TYPED, 21'h00, 1'b0, u8d_pkg::STATUS_REJECT, 1'b0, 32'd0},
      // two-byte character
      '{8'hC2, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'hA9, 1'b1, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      // E0 lead, lowest three-byte point
      '{8'hE0, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'hA0, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'h80, 1'b1, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      // ED lead into the surrogate range is rejected
      '{8'hED, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'hA0, 1'b1, TYPED, 21'h00, 1'b0, u8d_pkg::STATUS_REJECT, 1'b0, 32'd0},
      // top of the three-byte range
      '{8'hEF, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'hBF, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'hBF, 1'b1, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      // F0 lead, lowest four-byte point
      '{8'hF0, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'h90, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'h80, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'h80, 1'b1, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      // F4 lead, highest code point
      '{8'hF4, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'h8F, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'hBF, 1'b0, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      '{8'hBF, 1'b1, PRED,  21'h00, 1'b0, u8d_pkg::STATUS_ACCEPT, 1'b0, 32'd0},
      // string ends inside a sequence
      '{8'hC2, 1'b1, TYPED, 21'h00, 1'b0, u8d_pkg::STATUS_PENDING, 1'b0, 32'd0},
      // rejection stays until the string ends
      '{8'hFF, 1'b0, TYPED, 21'h00, 1'b0, u8d_pkg::STATUS_REJECT, 1'b0, 32'd0},
      '{8'h41, 1'b1, TYPED, 21'h00, 1'b0, u8d_pkg::STATUS_REJECT, 1'b0, 32'd0}
   };

   typedef struct packed {
      u8d_pkg::req_type item;
      logic             typed;
      u8d_pkg::rsp_type typed_rsp;
   } beat_plan_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   u8d_pkg::req_type req_item  = '0;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   u8d_pkg::rsp_type rsp_item;

   beat_plan_type    stim_q[$];
   u8d_pkg::rsp_type decode_q[$];

   // Decoder shadow state
   logic [3:0]  dec_state = u8d_pkg::ST_ACCEPT;
   logic [20:0] dec_acc   = '0;
   logic [31:0] dec_count = '0;

   int send_idx      = 0;
   int send_gap      = 0;
   logic send_calm   = 1'b0;
   int send_span     = 40;
   int recv_stall    = 0;
   logic recv_calm   = 1'b0;
   int recv_span     = 40;
   int beats_checked = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   utf8_stream_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Byte to character class
   function automatic logic [3:0] char_class_of(input logic [7:0] b);
      logic [3:0] cls;
      cls = u8d_pkg::CLS_INVALID;
      case (b[7:4])
         4'h8:       cls = u8d_pkg::CLS_CONT_LO;
         4'h9:       cls = u8d_pkg::CLS_CONT_MID;
         4'hA, 4'hB: cls = u8d_pkg::CLS_CONT_HI;
         4'hC, 4'hD: cls = (b < 8'hC2) ? u8d_pkg::CLS_INVALID : u8d_pkg::CLS_LEAD2;
         4'hE: begin
            if (b == 8'hE0)      cls = u8d_pkg::CLS_LEAD_E0;
            else if (b == 8'hED) cls = u8d_pkg::CLS_LEAD_ED;
            else                 cls = u8d_pkg::CLS_LEAD3;
         end
         4'hF: begin
            if (b == 8'hF0)      cls = u8d_pkg::CLS_LEAD_F0;
            else if (b < 8'hF4)  cls = u8d_pkg::CLS_LEAD4;
            else if (b == 8'hF4) cls = u8d_pkg::CLS_LEAD_F4;
            else                 cls = u8d_pkg::CLS_INVALID;
         end
         default:    cls = u8d_pkg::CLS_ASCII;
      endcase
      return cls;
   endfunction

   // DFA step; any state outside the known set rejects
   function automatic logic [3:0] dfa_advance(input logic [3:0] st, input logic [3:0] cls);
      logic cont_lo, cont_mid, cont_hi, cont_any;
      logic [3:0] nst;
      cont_lo  = (cls == u8d_pkg::CLS_CONT_LO);
      cont_mid = (cls == u8d_pkg::CLS_CONT_MID);
      cont_hi  = (cls == u8d_pkg::CLS_CONT_HI);
      cont_any = cont_lo | cont_mid | cont_hi;
      nst = u8d_pkg::ST_REJECT;
      case (st)
         u8d_pkg::ST_ACCEPT: begin
            case (cls)
               u8d_pkg::CLS_ASCII:   nst = u8d_pkg::ST_ACCEPT;
               u8d_pkg::CLS_LEAD2:   nst = S_NEED1;
               u8d_pkg::CLS_LEAD3:   nst = S_NEED2;
               u8d_pkg::CLS_LEAD_E0: nst = S_AFTER_E0;
               u8d_pkg::CLS_LEAD_ED: nst = S_AFTER_ED;
               u8d_pkg::CLS_LEAD_F0: nst = S_AFTER_F0;
               u8d_pkg::CLS_LEAD4:   nst = S_NEED3;
               u8d_pkg::CLS_LEAD_F4: nst = S_AFTER_F4;
               default:              nst = u8d_pkg::ST_REJECT;
            endcase
         end
         S_NEED1:    if (cont_any) nst = u8d_pkg::ST_ACCEPT;
         S_NEED2:    if (cont_any) nst = S_NEED1;
         S_AFTER_E0: if (cont_hi) nst = S_NEED1;
         S_AFTER_ED: if (cont_lo || cont_mid) nst = S_NEED1;
         S_AFTER_F0: if (cont_mid || cont_hi) nst = S_NEED2;
         S_NEED3:    if (cont_any) nst = S_NEED2;
         S_AFTER_F4: if (cont_lo) nst = S_NEED2;
         default:    nst = u8d_pkg::ST_REJECT;
      endcase
      return nst;
   endfunction

   // Decode one byte against the shadow state and form its result beat
   task automatic utf8_decode_step(input u8d_pkg::req_type beat,
                                   output u8d_pkg::rsp_type res);
      logic [3:0] cls;
      logic [3:0] nst;
      logic [7:0] lead_mask;
      cls = char_class_of(beat.data_byte);
      if (dec_state != u8d_pkg::ST_ACCEPT) begin
         dec_acc = {dec_acc[14:0], beat.data_byte[5:0]};
      end else begin
         lead_mask = 8'hFF >> cls;
         dec_acc = {13'd0, beat.data_byte & lead_mask};
      end
      nst = dfa_advance(dec_state, cls);
      dec_state = nst;
      res = '0;
      if (nst == u8d_pkg::ST_ACCEPT) begin
         if (dec_count != '1) dec_count = dec_count + 1;
         res.code_point = dec_acc;
         res.code_done  = 1'b1;
         res.status     = u8d_pkg::STATUS_ACCEPT;
      end else begin
         res.status = (nst == u8d_pkg::ST_REJECT) ? u8d_pkg::STATUS_REJECT
                                                  : u8d_pkg::STATUS_PENDING;
      end
      // End of string: report, then back to reset state
      if (beat.last_byte) begin
         if (nst == u8d_pkg::ST_ACCEPT) begin
            res.string_valid = 1'b1;
            res.char_count   = dec_count;
         end
         dec_state = u8d_pkg::ST_ACCEPT;
         dec_acc   = '0;
         dec_count = '0;
      end
   endtask

   // Idle length: mostly short, a few long, none in calm stretches
   function automatic int draw_gap(input logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic put_byte(input logic [7:0] b);
      beat_plan_type plan;
      plan = '0;
      plan.item.data_byte = b;
      stim_q.push_back(plan);
   endtask

   // Random code point from a random encoded length, edges favored
   function automatic logic [20:0] pick_code_point();
      logic [20:0] lo, hi, cp;
      case ($urandom_range(1, 4))
         1:       begin lo = 21'h00000; hi = 21'h0007F; end
         2:       begin lo = 21'h00080; hi = 21'h007FF; end
         3:       begin lo = 21'h00800; hi = 21'h0FFFF; end
         default: begin lo = 21'h10000; hi = 21'h10FFFF; end
      endcase
      case ($urandom_range(0, 7))
         0:       cp = lo;
         1:       cp = hi;
         default: cp = lo + 21'($urandom_range(0, int'(hi - lo)));
      endcase
      // steer off the surrogate block
      if (cp >= 21'h0D800 && cp <= 21'h0DFFF) cp = cp ^ 21'h00800;
      return cp;
   endfunction

   // Encode one character, optionally damaged
   task automatic put_char(input logic [20:0] cp, input int breakage);
      logic [7:0] seq [4];
      int n;
      int k;
      if (cp < 21'h80) begin
         seq[0] = {1'b0, cp[6:0]};
         n = 1;
      end else if (cp < 21'h800) begin
         seq[0] = {3'b110, cp[10:6]};
         seq[1] = {2'b10, cp[5:0]};
         n = 2;
      end else if (cp < 21'h10000) begin
         seq[0] = {4'b1110, cp[15:12]};
         seq[1] = {2'b10, cp[11:6]};
         seq[2] = {2'b10, cp[5:0]};
         n = 3;
      end else begin
         seq[0] = {5'b11110, cp[20:18]};
         seq[1] = {2'b10, cp[17:12]};
         seq[2] = {2'b10, cp[11:6]};
         seq[3] = {2'b10, cp[5:0]};
         n = 4;
      end
      if (breakage != BREAK_NONE && n == 1) begin
         seq[0] = 8'($urandom_range(8'h80, 8'hBF));
      end else if (breakage == BREAK_TRUNC) begin
         n = $urandom_range(1, n - 1);
      end else if (breakage == BREAK_CORRUPT) begin
         k = $urandom_range(1, n - 1);
         seq[k] = 8'($urandom_range(0, 255));
      end
      for (int i = 0; i < n; i++) put_byte(seq[i]);
   endtask

   // One random string: mostly well formed, some damaged, some raw noise
   task automatic gen_string();
      int kind;
      int nchar;
      int bad_at;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         nchar  = $urandom_range(1, 6);
         bad_at = (kind < 70) ? -1 : $urandom_range(0, nchar - 1);
         for (int i = 0; i < nchar; i++) begin
            put_char(pick_code_point(),
                     (i == bad_at) ? $urandom_range(BREAK_TRUNC, BREAK_CORRUPT) : BREAK_NONE);
         end
      end else begin
         nchar = (kind < 95) ? $urandom_range(2, 6) : 1;
         for (int i = 0; i < nchar; i++) put_byte(8'($urandom_range(0, 255)));
      end
      stim_q[stim_q.size() - 1].item.last_byte = 1'b1;
   endtask

   // Request side: predict each accepted beat, then offer the next one
   always @(posedge clock) begin
      logic took;
      logic push_n;
      int nidx;
      int gap_n;
      u8d_pkg::rsp_type res;
      if (reset) begin
         req_push <= 1'b0;
         req_item <= '0;
      end else begin
         took   = req_push && !req_full;
         nidx   = send_idx;
         gap_n  = send_gap;
         push_n = req_push;
         if (took) begin
            utf8_decode_step(req_item, res);
            if (stim_q[send_idx].typed) decode_q.push_back(stim_q[send_idx].typed_rsp);
            else decode_q.push_back(res);
            nidx = send_idx + 1;
            if (send_span == 0) begin
               send_calm <= ~send_calm;
               send_span <= $urandom_range(20, 100);
            end else begin
               send_span <= send_span - 1;
            end
         end
         if (!req_push || took) begin
            if (gap_n != 0) begin
               push_n = 1'b0;
               gap_n  = gap_n - 1;
            end else if (nidx < stim_q.size()) begin
               push_n = 1'b1;
               req_item <= stim_q[nidx].item;
               gap_n = draw_gap(send_calm);
            end else begin
               push_n = 1'b0;
            end
         end
         req_push <= push_n;
         send_idx <= nidx;
         send_gap <= gap_n;
      end
   end

   // Result side: check each popped beat against the oldest prediction
   always @(posedge clock) begin
      logic took;
      int stall_n;
      u8d_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         took    = rsp_pop && !rsp_empty;
         stall_n = recv_stall;
         if (took) begin
            beats_checked = beats_checked + 1;
            if (decode_q.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count = fail_count + 1;
            end else begin
               want = decode_q.pop_front();
               if (rsp_item.code_point !== want.code_point) begin
                  $error("code_point: expected %0h, actual %0h", want.code_point,
                         rsp_item.code_point);
                  fail_count = fail_count + 1;
               end
               if (rsp_item.code_done !== want.code_done) begin
                  $error("code_done: expected %0d, actual %0d", want.code_done,
                         rsp_item.code_done);
                  fail_count = fail_count + 1;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_item.status);
                  fail_count = fail_count + 1;
               end
               if (rsp_item.string_valid !== want.string_valid) begin
                  $error("string_valid: expected %0d, actual %0d", want.string_valid,
                         rsp_item.string_valid);
                  fail_count = fail_count + 1;
               end
               if (rsp_item.char_count !== want.char_count) begin
                  $error("char_count: expected %0d, actual %0d", want.char_count,
                         rsp_item.char_count);
                  fail_count = fail_count + 1;
               end
            end
            stall_n = draw_gap(recv_calm);
            if (recv_span == 0) begin
               recv_calm <= ~recv_calm;
               recv_span <= $urandom_range(20, 100);
            end else begin
               recv_span <= recv_span - 1;
            end
         end
         if (stall_n != 0) begin
            rsp_pop <= 1'b0;
            stall_n = stall_n - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
         recv_stall <= stall_n;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still expected", cycle_count,
                  decode_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      beat_plan_type plan;
      int strings_total;
      // Directed table first, then random strings
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         plan = '0;
         plan.item.data_byte       = DIRECTED[i].data;
         plan.item.last_byte       = DIRECTED[i].last;
         plan.typed                = DIRECTED[i].typed;
         plan.typed_rsp.code_point = DIRECTED[i].cp;
         plan.typed_rsp.code_done  = DIRECTED[i].done;
         plan.typed_rsp.status     = DIRECTED[i].status;
         plan.typed_rsp.string_valid = DIRECTED[i].valid;
         plan.typed_rsp.char_count = DIRECTED[i].count;
         stim_q.push_back(plan);
      end
      while (stim_q.size() < DIRECTED_ROWS + RANDOM_BYTES) gen_string();
      strings_total = 0;
      foreach (stim_q[i]) if (stim_q[i].item.last_byte) strings_total++;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // all bytes sent, all results back, then a quiet drain
      while (send_idx < stim_q.size() || req_push) @(posedge clock);
      while (decode_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d strings (%0d directed), checked %0d result beats",
               stim_q.size(), strings_total, DIRECTED_ROWS, beats_checked);
      $display("Random strings mixed well-formed, damaged and noise bytes; %0d mismatches",
               fail_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
